@@ design/gtf_pkg.sv @@
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared types and constants for the GTF display timing generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

    typedef struct packed {
        logic [13:0] active_width;
        logic [13:0] active_lines;
        logic [7:0]  refresh_hz;
    } t_gtf_req;

    typedef struct packed {
        logic [21:0] pixel_clock_khz;
        logic [13:0] h_display;
        logic [13:0] h_sync_start;
        logic [13:0] h_sync_end;
        logic [13:0] h_total;
        logic [13:0] v_display;
        logic [13:0] v_sync_start;
        logic [13:0] v_sync_end;
        logic [13:0] v_total;
        logic [7:0]  v_refresh;
    } t_gtf_mode;

    localparam logic [13:0] TIMING_MAX    = 14'd16383;
    localparam logic [21:0] CLOCK_MAX_KHZ = 22'd4000000;
    localparam logic [11:0] CLOCK_MAX_MHZ = 12'd4000;
    localparam logic [9:0]  KHZ_PER_MHZ   = 10'd1000;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    localparam logic [9:0]  VSYNC_BP_US   = 10'd550;
    localparam logic [3:0]  DUTY_DIV      = 4'd10;
    localparam logic [6:0]  HSYNC_DIV     = 7'd100;

    // round-to-nearest-even carry from a quotient's remainder
    function automatic logic rne_up(input logic [63:0] rem, input logic [63:0] den,
                                    input logic q_lsb);
        logic [64:0] r2;
        logic [64:0] d2;
        begin
            r2 = {rem, 1'b0};
            d2 = {1'b0, den};
            return (r2 > d2) || ((r2 == d2) && q_lsb);
        end
    endfunction

endpackage

`default_nettype wire

@@ design/gtf_div.sv @@
// ----------------------------------------------------------------------------
// gtf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// Requires num < den * 2**QW.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_div #(
    parameter int NW = 32,
    parameter int DW = 20,
    parameter int QW = 12,
    parameter int TW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem,
    output logic [DW-1:0]      o_den,
    output logic [TW-1:0]      o_tag
);

    localparam int EW = QW + DW;

    logic [EW-1:0] ext;
    logic [QW-1:0] r_vld;
    logic [DW-1:0] r_rem [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [TW-1:0] r_tag [0:QW-1];

    assign ext = EW'(i_num);

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic          a_vld;
        logic [DW-1:0] a_rem;
        logic [QW-1:0] a_low;
        logic [DW-1:0] a_den;
        logic [TW-1:0] a_tag;
        logic [DW:0]   trial;
        logic          fits;

        if (k == 0) begin : g_in
            assign a_vld = i_vld;
            assign a_rem = ext[EW-1:QW];
            assign a_low = ext[QW-1:0];
            assign a_den = i_den;
            assign a_tag = i_tag;
        end else begin : g_mid
            assign a_vld = r_vld[k-1];
            assign a_rem = r_rem[k-1];
            assign a_low = r_low[k-1];
            assign a_den = r_den[k-1];
            assign a_tag = r_tag[k-1];
        end

        assign trial = {a_rem, a_low[QW-1]};
        assign fits  = trial >= {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= fits ? DW'(trial - {1'b0, a_den}) : DW'(trial);
            r_low[k] <= {a_low[QW-2:0], fits};
            r_den[k] <= a_den;
            r_tag[k] <= a_tag;
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_low[QW-1];
    assign o_rem = r_rem[QW-1];
    assign o_den = r_den[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

`default_nettype wire

@@ design/gtf_display_timing_generator.sv @@
// ----------------------------------------------------------------------------
// gtf_display_timing_generator
// GTF progressive mode calculator, no margins, Q.FRAC_BITS fixed point.
// Four chained bit-per-stage division pipelines handle the variable divisors;
// the constant divisors use reciprocal multiply stages.
// Throughput: one word per cycle; busy is never raised, results cannot stall.
// Reset: synchronous, clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_display_timing_generator
    import gtf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_gtf_req  i_req,
    output logic           o_strobe,
    output t_gtf_mode      o_mode
);

    localparam int F    = FRAC_BITS;
    localparam int HPW  = 20 + F;
    localparam int DTW  = 5 + F;
    localparam int N3X  = 22 + F;
    localparam int N3W  = 9 + F;
    localparam int Q3W  = 9 + F;
    localparam int PRW  = 2 * N3W;
    localparam int RSH  = 12 + F;
    localparam int HSH  = 21;
    localparam int N4W  = 20 + F;
    localparam int D4W  = 11 + F;
    localparam int Q6W  = 15 + F;
    localparam int TW1  = 45;
    localparam int TW2  = 52;
    localparam int TW3  = TW2 + HPW;
    localparam int TW5  = 14 + TW3;
    localparam int TW6  = 15 + 15 + 14 + 12 + 14 + 8 + 15;

    localparam logic [HPW-1:0] NUM_HP   = HPW'(US_PER_SEC) << F;
    localparam logic [Q3W:0]   DUTY_MAX = (Q3W+1)'(30) << F;
    localparam logic [D4W-1:0] HUNDRED  = D4W'(100) << F;
    localparam logic [N3W-1:0] RCP10    = N3W'(((64'd1 << RSH) + 64'd9) / 64'd10);
    localparam logic [14:0]    RCP100   = 15'(((32'd1 << HSH) + 32'd99) / 32'd100);

    assign busy = 1'b0;

    // stage A: input capture
    logic     r_a_vld;
    t_gtf_req r_a_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_req <= i_req;
    end

    // stage B: cell rounding, vsync+bp ratio operands
    logic [7:0]  b_fe;
    logic        b_up;
    logic [14:0] b_hd;
    logic [17:0] b_k550;
    logic [14:0] b_v1;
    logic        r_b_vld;
    logic [31:0] r_b_num;
    logic [19:0] r_b_den;
    logic [TW1-1:0] r_b_tag;

    assign b_fe   = (r_a_req.refresh_hz == 8'd0) ? 8'd1 : r_a_req.refresh_hz;
    assign b_up   = (r_a_req.active_width[2:0] > 3'd4) ||
                    ((r_a_req.active_width[2:0] == 3'd4) && r_a_req.active_width[3]);
    assign b_hd   = 15'({r_a_req.active_width[13:3], 3'b000}) + (b_up ? 15'd8 : 15'd0);
    assign b_k550 = 18'(b_fe) * 18'(VSYNC_BP_US);
    assign b_v1   = 15'(r_a_req.active_lines) + 15'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_num <= 32'(b_k550) * 32'(b_v1);
        r_b_den <= US_PER_SEC - 20'(b_k550);
        r_b_tag <= {b_hd, r_a_req.active_lines, r_a_req.refresh_hz, b_fe};
    end

    logic           d1_vld;
    logic [11:0]    d1_quo;
    logic [19:0]    d1_rem;
    logic [19:0]    d1_den;
    logic [TW1-1:0] d1_tag;

    gtf_div #(.NW(32), .DW(20), .QW(12), .TW(TW1)) u_div_vbp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_b_vld), .i_num (r_b_num), .i_den (r_b_den), .i_tag (r_b_tag),
        .o_vld (d1_vld), .o_quo (d1_quo), .o_rem (d1_rem), .o_den (d1_den), .o_tag (d1_tag)
    );

    // stage C: total lines
    logic [14:0] c_hd;
    logic [13:0] c_v;
    logic [7:0]  c_fr;
    logic [7:0]  c_fe;
    logic [12:0] c_vspb;
    logic        r_c_vld;
    logic [14:0] r_c_tvl;
    logic [14:0] r_c_hd;
    logic [13:0] r_c_v;
    logic [7:0]  r_c_fr;
    logic [7:0]  r_c_fe;

    assign {c_hd, c_v, c_fr, c_fe} = d1_tag;
    assign c_vspb = 13'(d1_quo) +
                    13'(rne_up(64'(d1_rem), 64'(d1_den), d1_quo[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_tvl <= 15'(c_v) + 15'(c_vspb) + 15'd1;
        r_c_hd  <= c_hd;
        r_c_v   <= c_v;
        r_c_fr  <= c_fr;
        r_c_fe  <= c_fe;
    end

    // stage D: lines per second
    logic           r_d_vld;
    logic [22:0]    r_d_den;
    logic [TW2-1:0] r_d_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_den <= 23'(r_c_fe) * 23'(r_c_tvl);
        r_d_tag <= {r_c_hd, r_c_v, r_c_fr, r_c_tvl};
    end

    logic           d2_vld;
    logic [HPW-1:0] d2_quo;
    logic [22:0]    d2_rem;
    logic [22:0]    d2_den;
    logic [TW2-1:0] d2_tag;

    gtf_div #(.NW(HPW), .DW(23), .QW(HPW), .TW(TW2)) u_div_hp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_d_vld), .i_num (NUM_HP), .i_den (r_d_den), .i_tag (r_d_tag),
        .o_vld (d2_vld), .o_quo (d2_quo), .o_rem (d2_rem), .o_den (d2_den), .o_tag (d2_tag)
    );

    // stage E: line period; 3*period clamped where the duty cycle is zero anyway
    logic [HPW-1:0] e_hp;
    logic [N3X-1:0] e_n3;
    logic           r_e_vld;
    logic [N3W-1:0] r_e_num;
    logic [TW3-1:0] r_e_tag;

    assign e_hp = d2_quo + HPW'(rne_up(64'(d2_rem), 64'(d2_den), d2_quo[0]));
    assign e_n3 = (N3X'(e_hp) << 1) + N3X'(e_hp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_num <= (|e_n3[N3X-1:N3W]) ? '1 : e_n3[N3W-1:0];
        r_e_tag <= {d2_tag, e_hp};
    end

    // stage P: divide by ten, reciprocal product
    logic           r_p_vld;
    logic [PRW-1:0] r_p_prod;
    logic [N3W-1:0] r_p_num;
    logic [TW3-1:0] r_p_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_prod <= PRW'(r_e_num) * PRW'(RCP10);
        r_p_num  <= r_e_num;
        r_p_tag  <= r_e_tag;
    end

    // stage Q: quotient and remainder by ten
    logic [Q3W-1:0] q_quo;
    logic           r_q_vld;
    logic [Q3W-1:0] r_q_quo;
    logic [3:0]     r_q_rem;
    logic [TW3-1:0] r_q_tag;

    assign q_quo = Q3W'(r_p_prod >> RSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_quo <= q_quo;
        r_q_rem <= 4'(r_p_num - (q_quo << 3) - (q_quo << 1));
        r_q_tag <= r_p_tag;
    end

    // stage F: duty cycle, floored at zero
    logic [Q3W:0]   f_dsub;
    logic           r_f_vld;
    logic [DTW-1:0] r_f_duty;
    logic [TW3-1:0] r_f_tag;

    assign f_dsub = (Q3W+1)'(r_q_quo) +
                    (Q3W+1)'(rne_up(64'(r_q_rem), 64'(DUTY_DIV), r_q_quo[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_duty <= (f_dsub >= DUTY_MAX) ? '0 : DTW'(DUTY_MAX - f_dsub);
        r_f_tag  <= r_q_tag;
    end

    // stage G: blanking ratio operands
    logic           r_g_vld;
    logic [N4W-1:0] r_g_num;
    logic [D4W-1:0] r_g_den;
    logic [TW3-1:0] r_g_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_num <= N4W'(r_f_tag[TW3-1 -: 15]) * N4W'(r_f_duty);
        r_g_den <= D4W'(HUNDRED - D4W'(r_f_duty)) << 4;
        r_g_tag <= r_f_tag;
    end

    logic           d4_vld;
    logic [8:0]     d4_quo;
    logic [D4W-1:0] d4_rem;
    logic [D4W-1:0] d4_den;
    logic [TW3-1:0] d4_tag;

    gtf_div #(.NW(N4W), .DW(D4W), .QW(9), .TW(TW3)) u_div_hblank (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_g_vld), .i_num (r_g_num), .i_den (r_g_den), .i_tag (r_g_tag),
        .o_vld (d4_vld), .o_quo (d4_quo), .o_rem (d4_rem), .o_den (d4_den), .o_tag (d4_tag)
    );

    // stage H: blanking and total pixels
    logic [14:0]    h_hd;
    logic [9:0]     h_cells;
    logic [13:0]    h_hb;
    logic           r_h_vld;
    logic [14:0]    r_h_tp;
    logic [TW5-1:0] r_h_tag;

    assign h_hd    = d4_tag[TW3-1 -: 15];
    assign h_cells = 10'(d4_quo) + 10'(rne_up(64'(d4_rem), 64'(d4_den), d4_quo[0]));
    assign h_hb    = {h_cells, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= d4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_tp  <= h_hd + 15'(h_hb);
        r_h_tag <= {h_hb, d4_tag};
    end

    // stage S: divide by one hundred, reciprocal product
    logic           r_s_vld;
    logic [29:0]    r_s_prod;
    logic [14:0]    r_s_tp;
    logic [TW5-1:0] r_s_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_prod <= 30'(r_h_tp) * 30'(RCP100);
        r_s_tp   <= r_h_tp;
        r_s_tag  <= r_h_tag;
    end

    // stage T: quotient and remainder by one hundred
    logic [7:0]     t_quo;
    logic           r_t_vld;
    logic [7:0]     r_t_quo;
    logic [6:0]     r_t_rem;
    logic [14:0]    r_t_tp;
    logic [TW5-1:0] r_t_tag;

    assign t_quo = 8'(r_s_prod >> HSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else begin
            r_t_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_quo <= t_quo;
        r_t_rem <= 7'(r_s_tp - 15'(t_quo) * 15'(HSYNC_DIV));
        r_t_tp  <= r_s_tp;
        r_t_tag <= r_s_tag;
    end

    // stage I: sync width, clock ratio operands
    logic [13:0]    i_hb;
    logic [14:0]    i_hd;
    logic [13:0]    i_v;
    logic [7:0]     i_fr;
    logic [14:0]    i_tvl;
    logic [HPW-1:0] i_hp;
    logic [8:0]     i_cells;
    logic           r_i_vld;
    logic [Q6W-1:0] r_i_num;
    logic [HPW-1:0] r_i_den;
    logic [TW6-1:0] r_i_tag;

    assign {i_hb, i_hd, i_v, i_fr, i_tvl, i_hp} = r_t_tag;
    assign i_cells = 9'(r_t_quo) + 9'(rne_up(64'(r_t_rem), 64'(HSYNC_DIV), r_t_quo[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_num <= Q6W'(r_t_tp) << F;
        r_i_den <= i_hp;
        r_i_tag <= {i_hd, r_t_tp, i_hb, {i_cells, 3'b000}, i_v, i_fr, i_tvl};
    end

    logic           d6_vld;
    logic [Q6W-1:0] d6_quo;
    logic [HPW-1:0] d6_rem;
    logic [HPW-1:0] d6_den;
    logic [TW6-1:0] d6_tag;

    gtf_div #(.NW(Q6W), .DW(HPW), .QW(Q6W), .TW(TW6)) u_div_clk (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_i_vld), .i_num (r_i_num), .i_den (r_i_den), .i_tag (r_i_tag),
        .o_vld (d6_vld), .o_quo (d6_quo), .o_rem (d6_rem), .o_den (d6_den), .o_tag (d6_tag)
    );

    // stage J: clock and saturated timings
    logic [14:0]    j_hd;
    logic [13:0]    j_v;
    logic [14:0]    j_tp;
    logic [13:0]    j_hb;
    logic [11:0]    j_hs;
    logic [7:0]     j_fr;
    logic [14:0]    j_tvl;
    logic [Q6W:0]   j_mhz;
    logic [15:0]    j_hse;
    logic [16:0]    j_hss;
    logic [14:0]    j_v1;
    logic [14:0]    j_v4;
    logic           r_j_vld;
    t_gtf_mode      r_j_mode;

    assign {j_hd, j_tp, j_hb, j_hs, j_v, j_fr, j_tvl} = d6_tag;
    assign j_mhz = (Q6W+1)'(d6_quo) + (Q6W+1)'(d6_rem != '0);
    assign j_hse = 16'(j_hd) + 16'(j_hb[13:1]);
    assign j_hss = 17'(j_hse) - 17'(j_hs);
    assign j_v1  = 15'(j_v) + 15'd1;
    assign j_v4  = 15'(j_v) + 15'd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else begin
            r_j_vld <= d6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_mode.pixel_clock_khz <= (j_mhz > (Q6W+1)'(CLOCK_MAX_MHZ)) ? CLOCK_MAX_KHZ :
                                    22'(j_mhz[11:0]) * 22'(KHZ_PER_MHZ);
        r_j_mode.h_display    <= (j_hd > 15'(TIMING_MAX)) ? TIMING_MAX : j_hd[13:0];
        r_j_mode.h_sync_start <= j_hss[16] ? 14'd0 :
                                 (j_hss > 17'(TIMING_MAX)) ? TIMING_MAX : j_hss[13:0];
        r_j_mode.h_sync_end   <= (j_hse > 16'(TIMING_MAX)) ? TIMING_MAX : j_hse[13:0];
        r_j_mode.h_total      <= (j_tp > 15'(TIMING_MAX)) ? TIMING_MAX : j_tp[13:0];
        r_j_mode.v_display    <= j_v;
        r_j_mode.v_sync_start <= (j_v1 > 15'(TIMING_MAX)) ? TIMING_MAX : j_v1[13:0];
        r_j_mode.v_sync_end   <= (j_v4 > 15'(TIMING_MAX)) ? TIMING_MAX : j_v4[13:0];
        r_j_mode.v_total      <= (j_tvl > 15'(TIMING_MAX)) ? TIMING_MAX : j_tvl[13:0];
        r_j_mode.v_refresh    <= j_fr;
    end

    assign o_strobe = r_j_vld;
    assign o_mode   = r_j_mode;

endmodule

`default_nettype wire

@@ design/gtf_chk.sv @@
// ----------------------------------------------------------------------------
// gtf_chk
// Port-level checks for the GTF display timing generator.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_chk
    import gtf_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire t_gtf_req  i_req,
    input wire logic      o_strobe,
    input wire t_gtf_mode o_mode
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    a_vsync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_mode.v_display < 14'd16380)) |->
        ((o_mode.v_sync_start == o_mode.v_display + 14'd1) &&
         (o_mode.v_sync_end == o_mode.v_display + 14'd4)))
        else $error("vertical sync placement wrong");

    a_horder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_mode.h_sync_start <= o_mode.h_sync_end) &&
                      (o_mode.h_sync_end <= o_mode.h_total) &&
                      (o_mode.h_display <= o_mode.h_total)))
        else $error("horizontal timings out of order");

    a_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_mode.h_display[2:0] == 3'd0) || (o_mode.h_display == TIMING_MAX)))
        else $error("h_display not on a cell boundary");

    a_clk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_mode.pixel_clock_khz <= CLOCK_MAX_KHZ))
        else $error("pixel clock above limit");

endmodule

bind gtf_display_timing_generator gtf_chk u_gtf_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_mode   (o_mode)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GTF display timing generator: a directed table
// of edge requests followed by random requests under several idle patterns,
// every mode compared field by field against an in-bench GTF predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import gtf_pkg::*;

    localparam int FRAC    = 16;
    localparam int LATENCY = 70 + 2 * FRAC;
    localparam int N_RAND  = 550;
    localparam longint LIMIT_CYCLES = 400000;

    typedef struct {
        t_gtf_req  req;
        bit        has_exp;
        t_gtf_mode exp;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_gtf_req  i_req;
    logic      o_strobe;
    t_gtf_mode o_mode;

    t_gtf_mode mode_q[$];
    int        n_err = 0;
    int        n_modes = 0;
    int        n_sent = 0;
    int        idle_pct;
    longint    cycle_cnt = 0;
    t_stim_row rows[$];

    gtf_display_timing_generator #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_mode  (o_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned div_rne(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        if (d == 0) return 0;
        q = n / d;
        r = n % d;
        if (2 * r > d || (2 * r == d && q[0])) q++;
        return q;
    endfunction

    function automatic logic [13:0] clamp14(longint x);
        if (x < 0) return 14'd0;
        if (x > 16383) return TIMING_MAX;
        return x[13:0];
    endfunction

    function automatic t_gtf_mode gtf_mode(t_gtf_req r);
        t_gtf_mode m;
        longint unsigned w, v, f, hd, vspb, tvl, hp, duty, dsub, hb, tp, hs, mhz, one;
        w = r.active_width;
        v = r.active_lines;
        f = (r.refresh_hz == 0) ? 1 : r.refresh_hz;
        one = 64'd1 << FRAC;
        hd = div_rne(w, 8) * 8;
        vspb = div_rne(550 * f * (v + 1), 1000000 - 550 * f);
        tvl = v + vspb + 1;
        hp = div_rne(64'd1000000 << FRAC, f * tvl);
        dsub = div_rne(3 * hp, 10);
        duty = 30 * one;
        duty = (dsub >= duty) ? 0 : duty - dsub;
        hb = div_rne(hd * duty, (100 * one - duty) * 16) * 16;
        tp = hd + hb;
        hs = div_rne(tp, 100) * 8;
        mhz = ((tp << FRAC) + hp - 1) / hp;
        m.pixel_clock_khz = (mhz > 4000) ? CLOCK_MAX_KHZ : 22'(mhz * 1000);
        m.h_display    = clamp14(longint'(hd));
        m.h_sync_start = clamp14(longint'(hd) + longint'(hb / 2) - longint'(hs));
        m.h_sync_end   = clamp14(longint'(hd) + longint'(hb / 2));
        m.h_total      = clamp14(longint'(tp));
        m.v_display    = clamp14(longint'(v));
        m.v_sync_start = clamp14(longint'(v) + 1);
        m.v_sync_end   = clamp14(longint'(v) + 4);
        m.v_total      = clamp14(longint'(tvl));
        m.v_refresh    = r.refresh_hz;
        return m;
    endfunction

    task automatic report_err(string what, longint unsigned got, longint unsigned want);
        n_err++;
        $display("ERROR mode %0d: %s got %0d expected %0d", n_modes, what, got, want);
    endtask

    // checker: the receiver cannot stall, every strobe is a word
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_gtf_mode e;
            if (mode_q.size() == 0) begin
                report_err("unexpected word", 0, 0);
            end else begin
                e = mode_q.pop_front();
                if (o_mode.pixel_clock_khz !== e.pixel_clock_khz)
                    report_err("pixel_clock_khz", o_mode.pixel_clock_khz, e.pixel_clock_khz);
                if (o_mode.h_display !== e.h_display)
                    report_err("h_display", o_mode.h_display, e.h_display);
                if (o_mode.h_sync_start !== e.h_sync_start)
                    report_err("h_sync_start", o_mode.h_sync_start, e.h_sync_start);
                if (o_mode.h_sync_end !== e.h_sync_end)
                    report_err("h_sync_end", o_mode.h_sync_end, e.h_sync_end);
                if (o_mode.h_total !== e.h_total)
                    report_err("h_total", o_mode.h_total, e.h_total);
                if (o_mode.v_display !== e.v_display)
                    report_err("v_display", o_mode.v_display, e.v_display);
                if (o_mode.v_sync_start !== e.v_sync_start)
                    report_err("v_sync_start", o_mode.v_sync_start, e.v_sync_start);
                if (o_mode.v_sync_end !== e.v_sync_end)
                    report_err("v_sync_end", o_mode.v_sync_end, e.v_sync_end);
                if (o_mode.v_total !== e.v_total)
                    report_err("v_total", o_mode.v_total, e.v_total);
                if (o_mode.v_refresh !== e.v_refresh)
                    report_err("v_refresh", o_mode.v_refresh, e.v_refresh);
            end
            n_modes++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // hold start for one accepted word, with random idle gaps before it
    task automatic send_word(t_gtf_req r, t_gtf_mode e);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            i_req <= t_gtf_req'({$urandom, $urandom});
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        mode_q.push_back(e);
        n_sent++;
    endtask

    function automatic t_gtf_req rand_req();
        t_gtf_req r;
        int k;
        k = $urandom_range(9, 0);
        if (k < 6) begin
            r.active_width = 14'($urandom_range(8192, 64));
            r.active_lines = 14'($urandom_range(8192, 64));
            r.refresh_hz   = 8'($urandom_range(240, 24));
        end else if (k < 8) begin
            r.active_width = 14'($urandom_range(2048, 64));
            r.active_lines = 14'($urandom_range(1200, 64));
            r.refresh_hz   = 8'($urandom_range(75, 24));
        end else begin
            r = t_gtf_req'($urandom);
        end
        return r;
    endfunction

    function automatic t_stim_row mk_row(int w, int v, int f, bit typed, t_gtf_mode e);
        t_stim_row s;
        s.req.active_width = 14'(w);
        s.req.active_lines = 14'(v);
        s.req.refresh_hz   = 8'(f);
        s.has_exp = typed;
        s.exp = typed ? e : gtf_mode(s.req);
        return s;
    endfunction

    initial begin
        t_gtf_mode z;
        z = '0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;

        rows.push_back(mk_row(64, 64, 60, 0, z));
        rows.push_back(mk_row(8192, 8192, 240, 0, z));
        rows.push_back(mk_row(8192, 8192, 24, 0, z));
        rows.push_back(mk_row(64, 64, 240, 0, z));
        rows.push_back(mk_row(640, 480, 60, 0, z));
        rows.push_back(mk_row(1920, 1080, 60, 0, z));
        rows.push_back(mk_row(1280, 720, 50, 0, z));
        rows.push_back(mk_row(1366, 768, 75, 0, z));
        rows.push_back(mk_row(1364, 768, 60, 0, z));
        rows.push_back(mk_row(1028, 768, 60, 0, z));
        rows.push_back(mk_row(1020, 768, 60, 0, z));
        rows.push_back(mk_row(800, 600, 0, 0, z));
        rows.push_back(mk_row(0, 0, 0, 0, z));
        rows.push_back(mk_row(16383, 16383, 255, 0, z));
        rows.push_back(mk_row(16383, 16383, 1, 0, z));
        rows.push_back(mk_row(100, 16383, 255, 0, z));
        rows.push_back(mk_row(16383, 1, 1, 0, z));
        rows.push_back(mk_row(8192, 16000, 255, 0, z));
        rows.push_back(mk_row(2730, 5461, 170, 0, z));
        rows.push_back(mk_row(13653, 10922, 85, 0, z));
        // zero width: no pixels, so the clock and all horizontal fields are zero
        z.v_display = 14'd500;
        z.v_sync_start = 14'd501;
        z.v_sync_end = 14'd504;
        z.v_total = gtf_mode(t_gtf_req'({14'd0, 14'd500, 8'd60})).v_total;
        z.v_refresh = 8'd60;
        rows.push_back(mk_row(0, 500, 60, 1, z));
        // v_sync_start reaches the top value and v_sync_end saturates there
        z = gtf_mode(t_gtf_req'({14'd640, 14'd16382, 8'd30}));
        z.v_sync_end = TIMING_MAX;
        rows.push_back(mk_row(640, 16382, 30, 1, z));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].has_exp && rows[i].exp !== gtf_mode(rows[i].req))
                report_err("typed row vs predictor", i, 0);
            send_word(rows[i].req, rows[i].exp);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 62;
                2: idle_pct = 19;
                default: idle_pct = 62;
            endcase
            for (int n = 0; n < N_RAND / 4; n++) begin
                t_gtf_req r;
                r = rand_req();
                send_word(r, gtf_mode(r));
            end
        end
        start <= 1'b0;

        while (mode_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d mode requests (directed edges and random), checked %0d modes.",
                 n_sent, n_modes);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
